### rtl/running_median_with_bypass_unit_assert.svh
// Assertion macros shared by the running median checker.
`ifndef RUNNING_MEDIAN_WITH_BYPASS_UNIT_ASSERT_SVH
`define RUNNING_MEDIAN_WITH_BYPASS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMB_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmb: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmb: next-cycle implication failed");

`endif

### rtl/rmb_pkg.sv
// Shared types and constants for the running median filter.
package rmb_pkg;

  // Width and reset value of the jump threshold register.
  localparam int unsigned ThrBits = 16;
  localparam logic [ThrBits-1:0] ThrReset = 16'd64;

  // Status a cell hands to its right neighbor.
  typedef struct packed {
    logic below;       // new sample sorts ahead of this cell's value
    logic evict_upto;  // the oldest entry sits in this cell or further left
  } rmb_link_t;

endpackage

### rtl/rmb_cell.sv
// One cell of the sorted window chain: holds a value and its age.
module rmb_cell
  import rmb_pkg::*;
#(
  parameter int unsigned WINDOW      = 11,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned INDEX       = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [SAMPLE_BITS-1:0]      new_i,
  input  rmb_link_t                   left_link_i,
  input  logic [SAMPLE_BITS-1:0]      left_val_i,
  input  logic [$clog2(WINDOW)-1:0]   left_age_i,
  input  logic                        right_below_i,
  input  logic [SAMPLE_BITS-1:0]      right_val_i,
  input  logic [$clog2(WINDOW)-1:0]   right_age_i,
  output rmb_link_t                   link_o,
  output logic [SAMPLE_BITS-1:0]      val_o,
  output logic [$clog2(WINDOW)-1:0]   age_o
);

  localparam int unsigned AgeW = $clog2(WINDOW);
  localparam logic [AgeW-1:0] AgeOldest = AgeW'(WINDOW - 1);
  localparam logic [AgeW-1:0] AgeInit   = AgeW'(INDEX);

  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AgeW-1:0]        age_q, age_d;
  logic below, evict_here, evict_upto, src_below, prev_below;

  // Compare against the broadcast sample and locate the oldest entry.
  assign below      = new_i > val_q;
  assign evict_here = age_q == AgeOldest;
  assign evict_upto = left_link_i.evict_upto | evict_here;
  assign src_below  = evict_upto ? right_below_i : below;
  assign prev_below = left_link_i.evict_upto ? below : left_link_i.below;

  // Pick own, right, left or new value to close the gap and open the slot.
  always_comb begin
    priority if (!src_below) begin
      val_d = evict_upto ? right_val_i : val_q;
      age_d = (evict_upto ? right_age_i : age_q) + AgeW'(1);
    end else if (!prev_below) begin
      val_d = new_i;
      age_d = '0;
    end else begin
      val_d = left_link_i.evict_upto ? val_q : left_val_i;
      age_d = (left_link_i.evict_upto ? age_q : left_age_i) + AgeW'(1);
    end
  end

  // Hold the contents until a transaction advances the chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= AgeInit;
    end else if (shift_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign link_o.below      = below;
  assign link_o.evict_upto = evict_upto;
  assign val_o             = val_q;
  assign age_o             = age_q;

endmodule

### rtl/running_median_with_bypass_unit.sv
// Top level of the running median filter with jump bypass.
//
//  channel  | direction | signals                                  | payload
//  ---------+-----------+------------------------------------------+--------------------------
//  cfg      | in        | cfg_valid_i / cfg_ready_o                | cfg_data_i (jump threshold)
//  in       | in        | in_valid_i / in_ready_o                  | sample_i
//  out      | out       | out_valid_o / out_ready_i                | filtered_o, window_full_o,
//           |           |                                          | bypassed_o
//
// One sample per cycle is accepted while the output does not stall; its result is registered
// after stage one. The accepting edge updates the sorted cell chain, and the edge that
// moves the second stage compares the middle cell against the sample and loads the output register.
// A stalled output holds the second stage and with it the chain and in_ready_o.
// Reset loads the window with zeros and the threshold with 64; cfg is always ready.
module running_median_with_bypass_unit
  import rmb_pkg::*;
#(
  parameter int unsigned WINDOW      = 11,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [ThrBits-1:0]     cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] filtered_o,
  output logic                   window_full_o,
  output logic                   bypassed_o
);

  localparam int unsigned AgeW = $clog2(WINDOW);
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam int unsigned CmpW = (SAMPLE_BITS > ThrBits) ? SAMPLE_BITS : ThrBits;
  localparam int unsigned MidIdx = WINDOW >> 1;
  localparam logic [CntW-1:0] CntFull = CntW'(WINDOW);

  logic [ThrBits-1:0] thr_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               s1_valid_q, s1_full_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic               out_valid_q, out_full_q, out_byp_q;
  logic [SAMPLE_BITS-1:0] out_filt_q;
  logic               accept, s2_load;

  rmb_link_t              links [WINDOW];
  logic [SAMPLE_BITS-1:0] vals  [WINDOW];
  logic [AgeW-1:0]        ages  [WINDOW];

  // Handshakes: the second stage moves whenever the output slot frees up.
  assign s2_load     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s2_load;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Capture the threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Saturate the sample count at the window size.
  assign cnt_d = (cnt_q == CntFull) ? cnt_q : cnt_q + CntW'(1);

  // Chain of sorted cells, largest value in cell 0.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    rmb_link_t              left_link;
    logic [SAMPLE_BITS-1:0] left_val, right_val;
    logic [AgeW-1:0]        left_age, right_age;
    logic                   right_below;

    if (i == 0) begin : g_first
      assign left_link = '0;
      assign left_val  = '0;
      assign left_age  = '0;
    end else begin : g_mid
      assign left_link = links[i-1];
      assign left_val  = vals[i-1];
      assign left_age  = ages[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign right_below = 1'b1;
      assign right_val   = '0;
      assign right_age   = '0;
    end else begin : g_inner
      assign right_below = links[i+1].below;
      assign right_val   = vals[i+1];
      assign right_age   = ages[i+1];
    end

    rmb_cell #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .INDEX       (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .shift_i       (accept),
      .new_i         (sample_i),
      .left_link_i   (left_link),
      .left_val_i    (left_val),
      .left_age_i    (left_age),
      .right_below_i (right_below),
      .right_val_i   (right_val),
      .right_age_i   (right_age),
      .link_o        (links[i]),
      .val_o         (vals[i]),
      .age_o         (ages[i])
    );
  end

  // Stage one: hold the sample and the fill state beside the updated chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i;
      s1_full_q   <= cnt_d == CntFull;
    end
  end

  // Stage two: distance from the median and the bypass decision.
  logic [SAMPLE_BITS-1:0] med, diff, filt_d;
  logic                   byp_d;

  assign med    = vals[MidIdx];
  assign diff   = (s1_sample_q >= med) ? s1_sample_q - med : med - s1_sample_q;
  assign byp_d  = s1_full_q && (CmpW'(diff) >= CmpW'(thr_q));
  assign filt_d = !s1_full_q ? '0 : (byp_d ? s1_sample_q : med);

  // Output register: load on a free slot, drop on a taken transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_filt_q <= filt_d;
      out_full_q <= s1_full_q;
      out_byp_q  <= byp_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign filtered_o    = out_filt_q;
  assign window_full_o = out_full_q;
  assign bypassed_o    = out_byp_q;

endmodule

### rtl/rmb_checker.sv
// Port-level checker for the running median filter, bound to the top level.
`include "running_median_with_bypass_unit_assert.svh"

module rmb_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] filtered_o,
  input logic                   window_full_o,
  input logic                   bypassed_o
);

  // A bypass only happens on a full window.
  `RMB_ASSERT_IMPL(a_byp_needs_full, clk_i, rst_ni, out_valid_o && bypassed_o, window_full_o)

  // While filling, the result is zero and never bypassed.
  `RMB_ASSERT_IMPL(a_fill_zero, clk_i, rst_ni, out_valid_o && !window_full_o, filtered_o == '0 && !bypassed_o)

  // A stalled result stays valid.
  `RMB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // An accepted sample shows a valid result when the output is free.
  `RMB_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_valid_i && in_ready_o && !out_valid_o, ##1 out_valid_o)

endmodule

bind running_median_with_bypass_unit rmb_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rmb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .filtered_o    (filtered_o),
  .window_full_o (window_full_o),
  .bypassed_o    (bypassed_o)
);
